// ===== rtl/hik_pkg.sv =====
// Shared types, constants and arithmetic helpers for the hexapod inverse kinematics core.
// Depends on nothing; every other file of the block imports it.
package hik_pkg;

  // Number formats and loop counts.
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 20;
  localparam int NUM_LEGS     = 6;
  localparam int LEG_IDX_W    = 3;
  localparam int Q_FRAC       = 30;
  localparam int MW           = 36;
  localparam int ZW           = 34;
  localparam int AW           = (FRAC_BITS + 11 > 26) ? FRAC_BITS + 11 : 26;
  localparam int ZPW          = AW + 28;
  localparam int DW           = 40;
  localparam int KMAX         = DW - 31;
  localparam int KW           = 4;
  localparam int LW           = 32 + KMAX;
  localparam int SQ_STEPS     = 32;
  localparam int ADDR_W       = 5;
  localparam int REG_W        = 31;

  localparam logic [LEG_IDX_W-1:0] LAST_LEG = LEG_IDX_W'(NUM_LEGS - 1);

  // Fixed-point constants.
  localparam longint Q30_HALF  = 64'sd536870912;
  localparam longint SIN120    = 64'sd929887697;
  localparam longint GAIN_Q30  = 64'sd652032874;
  localparam longint DEG2RAD   = 64'sd74961321;
  localparam logic signed [AW-1:0] ANG_FULL    = AW'(360 <<< FRAC_BITS);
  localparam logic signed [AW-1:0] ANG_HALF    = AW'(180 <<< FRAC_BITS);
  localparam logic signed [AW-1:0] ANG_QUARTER = AW'(90 <<< FRAC_BITS);
  localparam longint ZRND = 64'sd1 <<< (FRAC_BITS + 1);

  // Arctangent of 2^-i in radians, Q2.30.
  localparam logic [31:0] ATAN_TAB [30] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536,
    32'd32768, 32'd16384, 32'd8192, 32'd4096, 32'd2048,
    32'd1024, 32'd512, 32'd256, 32'd128, 32'd64,
    32'd32, 32'd16, 32'd8, 32'd4, 32'd2
  };

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_UPPER_ARM  = 3'd0,
    REG_UPPER_HALF = 3'd1,
    REG_LOWER_ARM  = 3'd2,
    REG_LOWER_HALF = 3'd3,
    REG_MIN_LEG    = 3'd4
  } reg_idx_t;

  typedef logic signed [MW-1:0] q_t;
  typedef logic signed [31:0]   pos_t;

  // Rotation matrix rows used for x, y, z plus the translation.
  typedef struct packed {
    q_t   m00;
    q_t   m10;
    q_t   m01;
    q_t   m11;
    q_t   m02;
    q_t   m12;
    pos_t px;
    pos_t py;
    pos_t pz;
  } pose_t;

  // Joint coordinates of all six legs.
  typedef struct packed {
    q_t [NUM_LEGS-1:0] ux;
    q_t [NUM_LEGS-1:0] uy;
    q_t [NUM_LEGS-1:0] lx;
    q_t [NUM_LEGS-1:0] ly;
  } geo_t;

  // Side data that travels with a leg through the square root.
  typedef struct packed {
    logic [LEG_IDX_W-1:0] idx;
    logic                 last;
    logic [KW-1:0]        k;
  } leg_tag_t;

  // Q30 product, rounded to nearest with halves upward.
  function automatic q_t mul30(input q_t a, input q_t b);
    logic signed [2*MW-1:0] p;
    p = (2*MW)'(a) * (2*MW)'(b) + (2*MW)'(Q30_HALF);
    return p[MW+Q_FRAC-1:Q_FRAC];
  endfunction

endpackage

// ===== rtl/hexapod_inverse_kinematics_core.sv =====
// Top level of the hexapod inverse kinematics core.
// Depends on hik_pkg and instantiates hik_cfg, hik_pose and hik_leg.
//
// Usage:
// Geometry is written over the APB-style port (five registers at byte
// addresses 0, 4, 8, 12 and 16). A pose is one transfer on the in_ channel.
// For every pose the out_ channel gives six transfers, legs 0 to 5 in order,
// with out_last_leg high on leg 5.
// Path from a pose transfer to its first leg result: the pose pipeline
// (angle folding, radian conversion, 20 CORDIC stages, sign fix and two
// matrix stages), the sequencer, six leg stages, the 32-stage square root
// pipeline and the output register.
// Throughput: one leg result every cycle while the receiver is ready, as
// the leg sequencer sends the six legs of a pose through one shared leg
// pipeline. Poses advance only while the sequencer is idle or on its last leg.
// Reset clears all valid bits, the sequencer and the registers to zero; no
// clearing pass is needed. When the receiver stalls, every stage holds its
// contents and in_ready drops in the same cycle, so nothing is lost.
// Geometry settles through the registered steps of hik_cfg after a write.
module hexapod_inverse_kinematics_core import hik_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_pos_x,
  input  logic signed [31:0]   in_pos_y,
  input  logic signed [31:0]   in_pos_z,
  input  logic signed [24:0]   in_yaw_deg,
  input  logic signed [24:0]   in_pitch_deg,
  input  logic signed [24:0]   in_roll_deg,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LEG_IDX_W-1:0] out_leg_index,
  output logic [REG_W-1:0]     out_leg_length,
  output logic signed [31:0]   out_servo_stroke,
  output logic                 out_last_leg,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic             en, en_pose, seq_rdy, pose_vld;
  pose_t            pose;
  geo_t             geo;
  logic [REG_W-1:0] min_len;

  // Leg stages move when the output register is free or drained.
  assign en       = !out_valid || out_ready;
  assign en_pose  = en && seq_rdy;
  assign in_ready = en_pose;

  hik_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geo     (geo),
    .min_len (min_len)
  );

  hik_pose u_pose (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en_pose),
    .in_vld    (in_valid),
    .pos_x     (in_pos_x),
    .pos_y     (in_pos_y),
    .pos_z     (in_pos_z),
    .yaw_deg   (in_yaw_deg),
    .pitch_deg (in_pitch_deg),
    .roll_deg  (in_roll_deg),
    .pose_vld  (pose_vld),
    .pose      (pose)
  );

  hik_leg u_leg (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .pose_vld   (pose_vld),
    .pose       (pose),
    .geo        (geo),
    .min_len    (min_len),
    .seq_rdy    (seq_rdy),
    .out_vld    (out_valid),
    .out_idx    (out_leg_index),
    .out_len    (out_leg_length),
    .out_stroke (out_servo_stroke),
    .out_last   (out_last_leg)
  );

endmodule

// ===== rtl/hik_cfg.sv =====
// Configuration registers on an APB-style port and the derived joint geometry.
// Depends on hik_pkg for register indexes, geometry types and the Q30 multiply.
module hik_cfg import hik_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output geo_t              geo,
  output logic [REG_W-1:0]  min_len
);

  logic [REG_W-1:0] ua_r, ub_r, la_r, lb_r, minl_r;
  logic [2:0]       idx;
  logic             wr;
  q_t               ua, ub, la, lb;
  q_t               uac_r, uas_r, ubc_r, ubs_r, lac_r, las_r, lbc_r, lbs_r;
  geo_t             geo_r;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;

  // Register writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ua_r   <= '0;
      ub_r   <= '0;
      la_r   <= '0;
      lb_r   <= '0;
      minl_r <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_UPPER_ARM:  ua_r   <= pwdata[REG_W-1:0];
        REG_UPPER_HALF: ub_r   <= pwdata[REG_W-1:0];
        REG_LOWER_ARM:  la_r   <= pwdata[REG_W-1:0];
        REG_LOWER_HALF: lb_r   <= pwdata[REG_W-1:0];
        REG_MIN_LEG:    minl_r <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (idx)
      REG_UPPER_ARM:  prdata = {1'b0, ua_r};
      REG_UPPER_HALF: prdata = {1'b0, ub_r};
      REG_LOWER_ARM:  prdata = {1'b0, la_r};
      REG_LOWER_HALF: prdata = {1'b0, lb_r};
      REG_MIN_LEG:    prdata = {1'b0, minl_r};
      default:        prdata = '0;
    endcase
  end

  assign ua = $signed(MW'(ua_r));
  assign ub = $signed(MW'(ub_r));
  assign la = $signed(MW'(la_r));
  assign lb = $signed(MW'(lb_r));

  // First step: offsets turned by 120 degrees.
  always_ff @(posedge clk) begin
    uac_r <= mul30(ua, -MW'(Q30_HALF));
    uas_r <= mul30(ua, MW'(SIN120));
    ubc_r <= mul30(ub, -MW'(Q30_HALF));
    ubs_r <= mul30(ub, MW'(SIN120));
    lac_r <= mul30(la, -MW'(Q30_HALF));
    las_r <= mul30(la, MW'(SIN120));
    lbc_r <= mul30(lb, -MW'(Q30_HALF));
    lbs_r <= mul30(lb, MW'(SIN120));
  end

  // Second step: the six upper and six lower joint positions.
  always_ff @(posedge clk) begin
    geo_r.ux[0] <= ua;             geo_r.uy[0] <= ub;
    geo_r.ux[1] <= uac_r + ubs_r;  geo_r.uy[1] <= uas_r - ubc_r;
    geo_r.ux[2] <= uac_r - ubs_r;  geo_r.uy[2] <= uas_r + ubc_r;
    geo_r.ux[3] <= uac_r - ubs_r;  geo_r.uy[3] <= -uas_r - ubc_r;
    geo_r.ux[4] <= uac_r + ubs_r;  geo_r.uy[4] <= -uas_r + ubc_r;
    geo_r.ux[5] <= ua;             geo_r.uy[5] <= -ub;
    geo_r.lx[0] <= -lac_r + lbs_r; geo_r.ly[0] <= las_r + lbc_r;
    geo_r.lx[1] <= -lac_r - lbs_r; geo_r.ly[1] <= las_r - lbc_r;
    geo_r.lx[2] <= -la;            geo_r.ly[2] <= lb;
    geo_r.lx[3] <= -la;            geo_r.ly[3] <= -lb;
    geo_r.lx[4] <= -lac_r - lbs_r; geo_r.ly[4] <= -las_r + lbc_r;
    geo_r.lx[5] <= -lac_r + lbs_r; geo_r.ly[5] <= -las_r - lbc_r;
  end

  assign geo     = geo_r;
  assign min_len = minl_r;

endmodule

// ===== rtl/hik_pose.sv =====
// Pose pipeline: angle folding, three CORDIC sine/cosine lanes and the rotation matrix.
// Depends on hik_pkg for formats, the arctangent table and the Q30 multiply.
module hik_pose import hik_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [24:0] yaw_deg,
  input  logic signed [24:0] pitch_deg,
  input  logic signed [24:0] roll_deg,
  output logic              pose_vld,
  output pose_t             pose
);

  localparam int PD = CORDIC_STEPS + 5;

  logic                 vld_r [PD];
  pos_t                 px_r  [PD];
  pos_t                 py_r  [PD];
  pos_t                 pz_r  [PD];

  logic signed [AW-1:0] ang   [3];
  logic signed [AW-1:0] r_nxt [3];
  logic                 n_nxt [3];
  logic signed [AW-1:0] a_r_r [3];
  logic                 a_n_r [3];

  q_t                   cx_r   [CORDIC_STEPS+1][3];
  q_t                   cy_r   [CORDIC_STEPS+1][3];
  logic signed [ZW-1:0] cz_r   [CORDIC_STEPS+1][3];
  logic                 cn_r   [CORDIC_STEPS+1][3];
  q_t                   cx_nxt [CORDIC_STEPS][3];
  q_t                   cy_nxt [CORDIC_STEPS][3];
  logic signed [ZW-1:0] cz_nxt [CORDIC_STEPS][3];
  logic signed [ZW-1:0] z_nxt  [3];

  q_t s_r [3];
  q_t c_r [3];
  q_t e_ctcp_r, e_ctsp_r, e_stsr_r, e_crsp_r, e_crcp_r, e_stcr_r, e_srsp_r, e_srcp_r;
  q_t e_sp_r, e_cp_r;
  pose_t f_r;

  assign ang[0] = AW'(yaw_deg);
  assign ang[1] = AW'(pitch_deg);
  assign ang[2] = AW'(roll_deg);

  // Valid bits and translation travel alongside the angle work.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PD; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < PD; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r[0] <= pos_x;
      py_r[0] <= pos_y;
      pz_r[0] <= pos_z;
      for (int i = 1; i < PD; i++) begin
        px_r[i] <= px_r[i-1];
        py_r[i] <= py_r[i-1];
        pz_r[i] <= pz_r[i-1];
      end
    end
  end

  // Wrap into one turn and fold into the right half plane.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      r_nxt[l] = ang[l];
      n_nxt[l] = 1'b0;
      if (r_nxt[l] > ANG_HALF) r_nxt[l] = r_nxt[l] - ANG_FULL;
      if (r_nxt[l] < -ANG_HALF) r_nxt[l] = r_nxt[l] + ANG_FULL;
      if (r_nxt[l] > ANG_QUARTER) begin
        r_nxt[l] = r_nxt[l] - ANG_HALF;
        n_nxt[l] = 1'b1;
      end else if (r_nxt[l] < -ANG_QUARTER) begin
        r_nxt[l] = r_nxt[l] + ANG_HALF;
        n_nxt[l] = 1'b1;
      end
    end
  end

  // Degrees to Q30 radians, rounded.
  always_comb begin
    logic signed [ZPW-1:0] zp;
    for (int l = 0; l < 3; l++) begin
      zp = ZPW'(a_r_r[l]) * ZPW'(DEG2RAD) + ZPW'(ZRND);
      z_nxt[l] = zp[ZW+FRAC_BITS+1:FRAC_BITS+2];
    end
  end

  // One CORDIC rotation per stage in each lane.
  always_comb begin
    q_t dx, dy;
    logic signed [ZW-1:0] at;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      for (int l = 0; l < 3; l++) begin
        dx = cy_r[i][l] >>> i;
        dy = cx_r[i][l] >>> i;
        at = $signed(ZW'(ATAN_TAB[i]));
        if (!cz_r[i][l][ZW-1]) begin
          cx_nxt[i][l] = cx_r[i][l] - dx;
          cy_nxt[i][l] = cy_r[i][l] + dy;
          cz_nxt[i][l] = cz_r[i][l] - at;
        end else begin
          cx_nxt[i][l] = cx_r[i][l] + dx;
          cy_nxt[i][l] = cy_r[i][l] - dy;
          cz_nxt[i][l] = cz_r[i][l] + at;
        end
      end
    end
  end

  // Angle stages and CORDIC registers.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        a_r_r[l]   <= r_nxt[l];
        a_n_r[l]   <= n_nxt[l];
        cx_r[0][l] <= MW'(GAIN_Q30);
        cy_r[0][l] <= '0;
        cz_r[0][l] <= z_nxt[l];
        cn_r[0][l] <= a_n_r[l];
        for (int i = 0; i < CORDIC_STEPS; i++) begin
          cx_r[i+1][l] <= cx_nxt[i][l];
          cy_r[i+1][l] <= cy_nxt[i][l];
          cz_r[i+1][l] <= cz_nxt[i][l];
          cn_r[i+1][l] <= cn_r[i][l];
        end
        s_r[l] <= cn_r[CORDIC_STEPS][l] ? -cy_r[CORDIC_STEPS][l] : cy_r[CORDIC_STEPS][l];
        c_r[l] <= cn_r[CORDIC_STEPS][l] ? -cx_r[CORDIC_STEPS][l] : cx_r[CORDIC_STEPS][l];
      end
    end
  end

  // Matrix: lane 0 is yaw, lane 1 pitch, lane 2 roll. First the pairwise products.
  always_ff @(posedge clk) begin
    if (en) begin
      e_ctcp_r <= mul30(c_r[1], c_r[0]);
      e_ctsp_r <= mul30(c_r[1], s_r[0]);
      e_stsr_r <= mul30(s_r[1], s_r[2]);
      e_crsp_r <= mul30(c_r[2], s_r[0]);
      e_crcp_r <= mul30(c_r[2], c_r[0]);
      e_stcr_r <= mul30(s_r[1], c_r[2]);
      e_srsp_r <= mul30(s_r[2], s_r[0]);
      e_srcp_r <= mul30(s_r[2], c_r[0]);
      e_sp_r   <= s_r[0];
      e_cp_r   <= c_r[0];
    end
  end

  // Then the triple products and the sums.
  always_ff @(posedge clk) begin
    if (en) begin
      f_r.m00 <= e_ctcp_r;
      f_r.m10 <= -e_ctsp_r;
      f_r.m01 <= mul30(e_stsr_r, e_cp_r) + e_crsp_r;
      f_r.m11 <= e_crcp_r - mul30(e_stsr_r, e_sp_r);
      f_r.m02 <= e_srsp_r - mul30(e_stcr_r, e_cp_r);
      f_r.m12 <= mul30(e_stcr_r, e_sp_r) + e_srcp_r;
      f_r.px  <= px_r[PD-2];
      f_r.py  <= py_r[PD-2];
      f_r.pz  <= pz_r[PD-2];
    end
  end

  assign pose_vld = vld_r[PD-1];
  assign pose     = f_r;

endmodule

// ===== rtl/hik_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a side tag.
// Depends on hik_pkg for the step count and the leg tag type.
module hik_isqrt import hik_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  logic [63:0] n_i,
  input  leg_tag_t    tag_i,
  output logic        vld_o,
  output logic [31:0] root_o,
  output leg_tag_t    tag_o
);

  logic [63:0] n_r   [SQ_STEPS];
  logic [63:0] r_r   [SQ_STEPS];
  logic        v_r   [SQ_STEPS];
  leg_tag_t    t_r   [SQ_STEPS];
  logic [63:0] n_nxt [SQ_STEPS];
  logic [63:0] r_nxt [SQ_STEPS];

  // Restoring step: try the next bit pair against the remainder.
  always_comb begin
    logic [63:0] n_in, r_in, bitv, trial;
    for (int j = 0; j < SQ_STEPS; j++) begin
      n_in  = (j == 0) ? n_i : n_r[(j == 0) ? 0 : j-1];
      r_in  = (j == 0) ? '0  : r_r[(j == 0) ? 0 : j-1];
      bitv  = 64'(1) << (2 * (SQ_STEPS - 1 - j));
      trial = r_in + bitv;
      if (n_in >= trial) begin
        n_nxt[j] = n_in - trial;
        r_nxt[j] = (r_in >> 1) + bitv;
      end else begin
        n_nxt[j] = n_in;
        r_nxt[j] = r_in >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < SQ_STEPS; j++) v_r[j] <= 1'b0;
    end else if (en) begin
      v_r[0] <= vld_i;
      for (int j = 1; j < SQ_STEPS; j++) v_r[j] <= v_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0] <= tag_i;
      for (int j = 1; j < SQ_STEPS; j++) t_r[j] <= t_r[j-1];
      for (int j = 0; j < SQ_STEPS; j++) begin
        n_r[j] <= n_nxt[j];
        r_r[j] <= r_nxt[j];
      end
    end
  end

  assign vld_o  = v_r[SQ_STEPS-1];
  assign root_o = r_r[SQ_STEPS-1][31:0];
  assign tag_o  = t_r[SQ_STEPS-1];

endmodule

// ===== rtl/hik_leg.sv =====
// Leg sequencer and leg pipeline: six legs per pose, joint distance, length and stroke.
// Depends on hik_pkg and instantiates hik_isqrt.
module hik_leg import hik_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 pose_vld,
  input  pose_t                pose,
  input  geo_t                 geo,
  input  logic [REG_W-1:0]     min_len,
  output logic                 seq_rdy,
  output logic                 out_vld,
  output logic [LEG_IDX_W-1:0] out_idx,
  output logic [REG_W-1:0]     out_len,
  output logic signed [31:0]   out_stroke,
  output logic                 out_last
);

  // Sequencer state and held pose.
  logic                 busy_r;
  logic [LEG_IDX_W-1:0] cnt_r;
  pose_t                hold_r;

  // Stage S: one leg picked.
  logic                 s_vld_r, s_last_r;
  logic [LEG_IDX_W-1:0] s_idx_r;
  pose_t                s_pose_r;
  q_t                   s_ux_r, s_uy_r, s_lx_r, s_ly_r;

  // Stage 1: rotation products.
  logic                 l1_vld_r, l1_last_r;
  logic [LEG_IDX_W-1:0] l1_idx_r;
  q_t                   l1_t00_r, l1_t10_r, l1_t01_r, l1_t11_r, l1_t02_r, l1_t12_r;
  q_t                   l1_lx_r, l1_ly_r;
  pos_t                 l1_px_r, l1_py_r, l1_pz_r;

  // Stage 2: absolute coordinate differences.
  logic                 l2_vld_r, l2_last_r;
  logic [LEG_IDX_W-1:0] l2_idx_r;
  logic [DW-1:0]        l2_a_r, l2_b_r, l2_c_r;
  logic signed [DW-1:0] dx, dy, dz;

  // Stage 3: scaled into 31 bits.
  logic                 l3_vld_r, l3_last_r;
  logic [LEG_IDX_W-1:0] l3_idx_r;
  logic [KW-1:0]        l3_k_r, k_nxt;
  logic [30:0]          l3_a_r, l3_b_r, l3_c_r;
  logic [DW-1:0]        orv;

  // Stage 4: squares. Stage 5: sum.
  logic                 l4_vld_r, l5_vld_r;
  leg_tag_t             l4_tag_r, l5_tag_r;
  logic [61:0]          l4_a_r, l4_b_r, l4_c_r;
  logic [63:0]          l5_sum_r;

  // Square root and output stage.
  logic                 q_vld;
  logic [31:0]          q_root;
  leg_tag_t             q_tag;
  logic [LW-1:0]        len;
  logic signed [LW+1:0] stroke;
  logic                 o_vld_r, o_last_r;
  logic [LEG_IDX_W-1:0] o_idx_r;
  logic [REG_W-1:0]     o_len_r;
  logic signed [31:0]   o_stroke_r;

  assign seq_rdy = !busy_r || (cnt_r == LAST_LEG);

  // Sequencer: hold a pose while its six legs go out, one leg per transfer slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (en) begin
      if (seq_rdy) begin
        busy_r <= pose_vld;
        cnt_r  <= '0;
      end else begin
        cnt_r  <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && seq_rdy && pose_vld) hold_r <= pose;
  end

  // Valid bits of the leg stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r  <= 1'b0;
      l1_vld_r <= 1'b0;
      l2_vld_r <= 1'b0;
      l3_vld_r <= 1'b0;
      l4_vld_r <= 1'b0;
      l5_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else if (en) begin
      s_vld_r  <= busy_r;
      l1_vld_r <= s_vld_r;
      l2_vld_r <= l1_vld_r;
      l3_vld_r <= l2_vld_r;
      l4_vld_r <= l3_vld_r;
      l5_vld_r <= l4_vld_r;
      o_vld_r  <= q_vld;
    end
  end

  // Stage S: pick the joints of the current leg.
  always_ff @(posedge clk) begin
    if (en) begin
      s_idx_r  <= cnt_r;
      s_last_r <= (cnt_r == LAST_LEG);
      s_pose_r <= hold_r;
      s_ux_r   <= $signed(geo.ux[cnt_r]);
      s_uy_r   <= $signed(geo.uy[cnt_r]);
      s_lx_r   <= $signed(geo.lx[cnt_r]);
      s_ly_r   <= $signed(geo.ly[cnt_r]);
    end
  end

  // Stage 1: rotate the upper joint.
  always_ff @(posedge clk) begin
    if (en) begin
      l1_idx_r  <= s_idx_r;
      l1_last_r <= s_last_r;
      l1_t00_r  <= mul30(s_pose_r.m00, s_ux_r);
      l1_t10_r  <= mul30(s_pose_r.m10, s_uy_r);
      l1_t01_r  <= mul30(s_pose_r.m01, s_ux_r);
      l1_t11_r  <= mul30(s_pose_r.m11, s_uy_r);
      l1_t02_r  <= mul30(s_pose_r.m02, s_ux_r);
      l1_t12_r  <= mul30(s_pose_r.m12, s_uy_r);
      l1_lx_r   <= s_lx_r;
      l1_ly_r   <= s_ly_r;
      l1_px_r   <= s_pose_r.px;
      l1_py_r   <= s_pose_r.py;
      l1_pz_r   <= s_pose_r.pz;
    end
  end

  // Stage 2: translate, subtract the lower joint, take magnitudes.
  assign dx = DW'(l1_t00_r) + DW'(l1_t10_r) + DW'(l1_px_r) - DW'(l1_lx_r);
  assign dy = DW'(l1_t01_r) + DW'(l1_t11_r) + DW'(l1_py_r) - DW'(l1_ly_r);
  assign dz = DW'(l1_t02_r) + DW'(l1_t12_r) + DW'(l1_pz_r);

  always_ff @(posedge clk) begin
    if (en) begin
      l2_idx_r  <= l1_idx_r;
      l2_last_r <= l1_last_r;
      l2_a_r    <= dx[DW-1] ? DW'(-dx) : DW'(dx);
      l2_b_r    <= dy[DW-1] ? DW'(-dy) : DW'(dy);
      l2_c_r    <= dz[DW-1] ? DW'(-dz) : DW'(dz);
    end
  end

  // Stage 3: halve all three until each fits in 31 bits.
  assign orv = l2_a_r | l2_b_r | l2_c_r;

  always_comb begin
    k_nxt = '0;
    for (int j = 0; j < KMAX; j++) begin
      if (orv[31+j]) k_nxt = KW'(j + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l3_idx_r  <= l2_idx_r;
      l3_last_r <= l2_last_r;
      l3_k_r    <= k_nxt;
      l3_a_r    <= 31'(l2_a_r >> k_nxt);
      l3_b_r    <= 31'(l2_b_r >> k_nxt);
      l3_c_r    <= 31'(l2_c_r >> k_nxt);
    end
  end

  // Stages 4 and 5: squares, then their sum.
  always_ff @(posedge clk) begin
    if (en) begin
      l4_tag_r.idx  <= l3_idx_r;
      l4_tag_r.last <= l3_last_r;
      l4_tag_r.k    <= l3_k_r;
      l4_a_r        <= 62'(l3_a_r) * 62'(l3_a_r);
      l4_b_r        <= 62'(l3_b_r) * 62'(l3_b_r);
      l4_c_r        <= 62'(l3_c_r) * 62'(l3_c_r);
      l5_tag_r      <= l4_tag_r;
      l5_sum_r      <= 64'(l4_a_r) + 64'(l4_b_r) + 64'(l4_c_r);
    end
  end

  hik_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (l5_vld_r),
    .n_i    (l5_sum_r),
    .tag_i  (l5_tag_r),
    .vld_o  (q_vld),
    .root_o (q_root),
    .tag_o  (q_tag)
  );

  // Output stage: scale back, saturate length and stroke.
  assign len    = LW'(q_root) << q_tag.k;
  assign stroke = $signed({2'b00, len}) - $signed((LW+2)'(min_len));

  always_ff @(posedge clk) begin
    if (en) begin
      o_idx_r  <= q_tag.idx;
      o_last_r <= q_tag.last;
      o_len_r  <= (len[LW-1:REG_W] != '0) ? {REG_W{1'b1}} : len[REG_W-1:0];
      if (stroke > $signed((LW+2)'(32'h7FFF_FFFF))) begin
        o_stroke_r <= 32'sh7FFF_FFFF;
      end else if (stroke < -$signed((LW+2)'(33'h1_0000_0000 >> 1))) begin
        o_stroke_r <= 32'sh8000_0000;
      end else begin
        o_stroke_r <= stroke[31:0];
      end
    end
  end

  assign out_vld    = o_vld_r;
  assign out_idx    = o_idx_r;
  assign out_len    = o_len_r;
  assign out_stroke = o_stroke_r;
  assign out_last   = o_last_r;

`ifndef SYNTHESIS
  // The leg counter never runs past the last leg.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= LAST_LEG)
    else $error("leg counter out of range");

  // The last flag marks exactly the sixth leg of a pose.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r |-> (o_last_r == (o_idx_r == LAST_LEG)))
    else $error("last flag does not match leg index");

  // A pose in progress keeps the sequencer busy and steps the counter by one.
  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    (en && busy_r && cnt_r != LAST_LEG) |=> (busy_r && cnt_r == $past(cnt_r) + 3'd1))
    else $error("sequencer lost a pose");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the hexapod inverse kinematics core.
// Predicts the six leg results of every pose with its own fixed-point model.
// Depends on hik_pkg and the RTL top level hexapod_inverse_kinematics_core.
module testbench import hik_pkg::*; ();

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES = 400;
  localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(20);
  localparam longint MM = 64'sd65536;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [24:0] yaw;
    logic signed [24:0] pitch;
    logic signed [24:0] roll;
  } pose_cmd_t;

  typedef struct {
    logic [LEG_IDX_W-1:0] idx;
    logic [REG_W-1:0]     len;
    logic signed [31:0]   stroke;
    logic                 last;
  } leg_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [24:0] in_yaw_deg = '0, in_pitch_deg = '0, in_roll_deg = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [LEG_IDX_W-1:0] out_leg_index;
  logic [REG_W-1:0] out_leg_length;
  logic signed [31:0] out_servo_stroke;
  logic out_last_leg;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Geometry as the predictor sees it.
  longint geo_reg [5];
  leg_result_t leg_expect [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_token = 0;

  hexapod_inverse_kinematics_core u_top (.*);

  always #1 clk = ~clk;

  // Q2.30 product, rounded to nearest with halves upward.
  function automatic longint mul_q30(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Sine and cosine in Q2.30 of an angle in fixed-point degrees.
  task automatic cordic_sin_cos(input longint deg, output longint s, output longint c);
    longint full, half, quarter, r, x, y, z, t, dx, dy;
    bit flip;
    full = 64'sd360 <<< FRAC_BITS;
    half = 64'sd180 <<< FRAC_BITS;
    quarter = 64'sd90 <<< FRAC_BITS;
    r = deg % full;
    flip = 1'b0;
    x = GAIN_Q30;
    y = 0;
    if (r > half) r -= full;
    if (r < -half) r += full;
    if (r > quarter) begin
      r -= half;
      flip = 1'b1;
    end else if (r < -quarter) begin
      r += half;
      flip = 1'b1;
    end
    z = (r * DEG2RAD + (64'sd1 <<< (FRAC_BITS + 1))) >>> (FRAC_BITS + 2);
    for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        t = x - dx;
        y = y + dy;
        z -= longint'(ATAN_TAB[i]);
      end else begin
        t = x + dx;
        y = y - dy;
        z += longint'(ATAN_TAB[i]);
      end
      x = t;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endtask

  // Floor of the square root.
  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Euclidean length; huge differences are halved first and the root scaled back.
  function automatic longint leg_span(longint dx, longint dy, longint dz);
    longint unsigned a, b, c;
    int k;
    a = dx < 0 ? -dx : dx;
    b = dy < 0 ? -dy : dy;
    c = dz < 0 ? -dz : dz;
    k = 0;
    while (a >= 64'd2147483648 || b >= 64'd2147483648 || c >= 64'd2147483648) begin
      a >>= 1;
      b >>= 1;
      c >>= 1;
      k++;
    end
    return longint'(root64(a * a + b * b + c * c) << k);
  endfunction

  // Queue the six leg results of one accepted pose.
  task automatic predict_legs(pose_cmd_t p);
    longint sp, cp, st, ct, sr, cr;
    longint m00, m10, m01, m11, m02, m12;
    longint ua, ub, la, lb, uac, uas, ubc, ubs, lac, las, lbc, lbs;
    longint ux [6], uy [6], lx [6], ly [6];
    longint gx, gy, gz, len, stroke;
    leg_result_t r;
    cordic_sin_cos(longint'(p.yaw), sp, cp);
    cordic_sin_cos(longint'(p.pitch), st, ct);
    cordic_sin_cos(longint'(p.roll), sr, cr);
    m00 = mul_q30(ct, cp);
    m10 = -mul_q30(ct, sp);
    m01 = mul_q30(mul_q30(st, sr), cp) + mul_q30(cr, sp);
    m11 = -mul_q30(mul_q30(st, sr), sp) + mul_q30(cr, cp);
    m02 = -mul_q30(mul_q30(st, cr), cp) + mul_q30(sr, sp);
    m12 = mul_q30(mul_q30(st, cr), sp) + mul_q30(sr, cp);
    ua = geo_reg[REG_UPPER_ARM];
    ub = geo_reg[REG_UPPER_HALF];
    la = geo_reg[REG_LOWER_ARM];
    lb = geo_reg[REG_LOWER_HALF];
    uac = mul_q30(ua, -Q30_HALF);
    uas = mul_q30(ua, SIN120);
    ubc = mul_q30(ub, -Q30_HALF);
    ubs = mul_q30(ub, SIN120);
    lac = mul_q30(la, -Q30_HALF);
    las = mul_q30(la, SIN120);
    lbc = mul_q30(lb, -Q30_HALF);
    lbs = mul_q30(lb, SIN120);
    // Joint pairs sit 120 degrees apart on both platforms.
    ux[0] = ua;        uy[0] = ub;
    ux[1] = uac + ubs; uy[1] = uas - ubc;
    ux[2] = uac - ubs; uy[2] = uas + ubc;
    ux[3] = uac - ubs; uy[3] = -uas - ubc;
    ux[4] = uac + ubs; uy[4] = -uas + ubc;
    ux[5] = ua;        uy[5] = -ub;
    lx[0] = -lac + lbs; ly[0] = las + lbc;
    lx[1] = -lac - lbs; ly[1] = las - lbc;
    lx[2] = -la;        ly[2] = lb;
    lx[3] = -la;        ly[3] = -lb;
    lx[4] = -lac - lbs; ly[4] = -las + lbc;
    lx[5] = -lac + lbs; ly[5] = -las - lbc;
    for (int i = 0; i < NUM_LEGS; i++) begin
      gx = mul_q30(m00, ux[i]) + mul_q30(m10, uy[i]) + longint'(p.pos_x);
      gy = mul_q30(m01, ux[i]) + mul_q30(m11, uy[i]) + longint'(p.pos_y);
      gz = mul_q30(m02, ux[i]) + mul_q30(m12, uy[i]) + longint'(p.pos_z);
      len = leg_span(gx - lx[i], gy - ly[i], gz);
      stroke = len - geo_reg[REG_MIN_LEG];
      if (stroke > 64'sd2147483647) stroke = 64'sd2147483647;
      if (stroke < -64'sd2147483648) stroke = -64'sd2147483648;
      r.idx = LEG_IDX_W'(i);
      r.len = (len > 64'sd2147483647) ? '1 : REG_W'(len);
      r.stroke = 32'(stroke);
      r.last = (i == NUM_LEGS - 1);
      leg_expect.push_back(r);
    end
  endtask

  // One register write: setup cycle, then access cycle.
  task automatic cfg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr / 4 <= REG_MIN_LEG) geo_reg[addr / 4] = longint'(data[REG_W-1:0]);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_geometry(longint ua, longint ub, longint la, longint lb, longint ml);
    cfg_write(ADDR_W'(REG_UPPER_ARM * 4), 32'(ua));
    cfg_write(ADDR_W'(REG_UPPER_HALF * 4), 32'(ub));
    cfg_write(ADDR_W'(REG_LOWER_ARM * 4), 32'(la));
    cfg_write(ADDR_W'(REG_LOWER_HALF * 4), 32'(lb));
    cfg_write(ADDR_W'(REG_MIN_LEG * 4), 32'(ml));
  endtask

  // Offer one pose, after idle cycles drawn one by one, and wait for its transfer.
  task automatic send_pose(pose_cmd_t p);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= p.pos_x;
    in_pos_y <= p.pos_y;
    in_pos_z <= p.pos_z;
    in_yaw_deg <= p.yaw;
    in_pitch_deg <= p.pitch;
    in_roll_deg <= p.roll;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_legs(p);
  endtask

  task automatic send(longint x, longint y, longint z, longint yw, longint pt, longint rl);
    pose_cmd_t p;
    p.pos_x = 32'(x);
    p.pos_y = 32'(y);
    p.pos_z = 32'(z);
    p.yaw = 25'(yw);
    p.pitch = 25'(pt);
    p.roll = 25'(rl);
    send_pose(p);
  endtask

  // Stop offering and wait until every leg result has arrived.
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (leg_expect.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_pos();
    if ($urandom_range(9) == 0) return $urandom;
    return 32'($urandom_range(0, 600 * 65536) - 300 * 65536);
  endfunction

  function automatic logic signed [24:0] rand_angle();
    case ($urandom_range(9))
      0: return 25'($urandom);
      1, 2: return 25'($urandom_range(0, 360 * 65536) - 180 * 65536);
      default: return 25'($urandom_range(0, 60 * 65536) - 30 * 65536);
    endcase
  endfunction

  task automatic send_random_poses(int count);
    pose_cmd_t p;
    repeat (count) begin
      p.pos_x = rand_pos();
      p.pos_y = rand_pos();
      p.pos_z = rand_pos();
      p.yaw = rand_angle();
      p.pitch = rand_angle();
      p.roll = rand_angle();
      send_pose(p);
    end
  endtask

  task automatic random_geometry();
    if ($urandom_range(4) == 0) begin
      set_geometry($urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      set_geometry($urandom_range(20 * 65536, 200 * 65536), $urandom_range(0, 40 * 65536),
                   $urandom_range(20 * 65536, 250 * 65536), $urandom_range(0, 40 * 65536),
                   $urandom_range(0, 300 * 65536));
    end
  endtask

  // Geometry straight out of reset is all zero: the leg is the translation alone.
  task automatic test_reset_geometry();
    send(0, 0, 0, 0, 0, 0);
    send(3 * MM, -4 * MM, 12 * MM, 30 * MM, 0, 0);
    send(-1, 1, 200 * MM, 0, 45 * MM, -45 * MM);
    wait_drain();
  endtask

  // Field extremes and the angle folding cases with a typical geometry.
  task automatic test_directed_poses();
    set_geometry(80 * MM, 20 * MM, 100 * MM, 15 * MM, 150 * MM);
    send(0, 0, 0, 0, 0, 0);
    send(0, 0, 200 * MM, 0, 0, 0);
    send(64'sd2147483647, 0, 200 * MM, 0, 0, 0);
    send(-64'sd2147483648, 0, 200 * MM, 0, 0, 0);
    send(0, 64'sd2147483647, 0, 0, 0, 0);
    send(0, -64'sd2147483648, 0, 0, 0, 0);
    send(0, 0, 64'sd2147483647, 0, 0, 0);
    send(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 0, 0, 0);
    send(0, 0, 200 * MM, 180 * MM, -180 * MM, 0);
    send(0, 0, 200 * MM, 90 * MM, -90 * MM, 0);
    send(0, 0, 200 * MM, 91 * MM, -91 * MM, 179 * MM);
    send(0, 0, 200 * MM, 270 * MM, -300 * MM, 360 * MM);
    send(0, 0, 200 * MM, 16777215, -16777216, 1);
    send(0, 0, 200 * MM, -1, 16777215, -16777216);
    send(10 * MM, -5 * MM, 180 * MM, 15 * MM, 45 * MM, -30 * MM);
    send(-20 * MM, 30 * MM, 220 * MM, -179 * MM, 89 * MM, -90 * MM);
    send(1, -1, 1, 11796480, -11796480, 11796480);
    send(0, 0, 200 * MM, 5898240, 5898241, -5898241);
    wait_drain();
  endtask

  // Register extremes: masking of the top data bit, huge legs, stroke saturation.
  task automatic test_geometry_extremes();
    set_geometry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(0, 0, 0, 0, 0, 0);
    send(64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 45 * MM, 30 * MM, 60 * MM);
    send(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648, 180 * MM, 90 * MM, -90 * MM);
    wait_drain();
    set_geometry(0, 0, 0, 0, 64'sd2147483647);
    // A write beyond the last register must leave the geometry alone.
    cfg_write(UNUSED_ADDR, 32'h1234_5678);
    send(0, 0, 0, 0, 0, 0);
    send(64'sd2147483647, -64'sd2147483648, 64'sd2147483647, 0, 0, 0);
    wait_drain();
    set_geometry(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0);
    send(0, 0, 0, 0, 0, 0);
    send(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648, -90 * MM, 180 * MM, 45 * MM);
    wait_drain();
  endtask

  // Random poses under each idling pattern, with a fresh geometry per pattern.
  task automatic test_random_traffic();
    random_geometry();
    send_idle_pct = 33;
    recv_idle_pct = 53;
    send_random_poses(100);
    wait_drain();
    random_geometry();
    send_idle_pct = 53;
    recv_idle_pct = 33;
    send_random_poses(100);
    wait_drain();
    random_geometry();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_poses(100);
    wait_drain();
  endtask

  // The receiver stalls for a long stretch while poses keep coming.
  task automatic test_backpressure();
    set_geometry(80 * MM, 20 * MM, 100 * MM, 15 * MM, 150 * MM);
    hold_token++;
    send_random_poses(30);
    wait_drain();
  endtask

  // Receiver: random ready, or a long hold-off when one is requested.
  int hold_seen = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result transfer with the oldest expected leg.
  always @(posedge clk) begin
    leg_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (leg_expect.size() == 0) begin
        errors++;
        $display("%0t: unexpected result leg %0d length %0d", $time, out_leg_index,
                 out_leg_length);
      end else begin
        e = leg_expect.pop_front();
        if (out_leg_index !== e.idx) begin
          errors++;
          $display("%0t: leg_index expected %0d actual %0d", $time, e.idx, out_leg_index);
        end
        if (out_leg_length !== e.len) begin
          errors++;
          $display("%0t: leg %0d leg_length expected %0d actual %0d", $time, e.idx, e.len,
                   out_leg_length);
        end
        if (out_servo_stroke !== e.stroke) begin
          errors++;
          $display("%0t: leg %0d servo_stroke expected %0d actual %0d", $time, e.idx,
                   e.stroke, out_servo_stroke);
        end
        if (out_last_leg !== e.last) begin
          errors++;
          $display("%0t: leg %0d last_leg expected %0b actual %0b", $time, e.idx, e.last,
                   out_last_leg);
        end
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 5; i++) geo_reg[i] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_geometry();
    test_directed_poses();
    test_geometry_extremes();
    test_random_traffic();
    test_backpressure();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && leg_expect.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
